FILE: rtl/psc_pkg.sv
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types, constants and arithmetic helpers of the sensor compensation.
// ----------------------------------------------------------------------------
package psc_pkg;

	localparam int FINE_LAT  = 4;
	localparam int DIV_W     = 32;
	localparam int DIV_TAG_W = 3;
	localparam int PRESS_LAT = 6 + DIV_W + 4;
	localparam int HUM_LAT   = 10;
	localparam int TOTAL_LAT = FINE_LAT + PRESS_LAT;

	localparam logic [31:0] PRESS_MIN = 32'd30000;
	localparam logic [31:0] PRESS_MAX = 32'd110000;
	localparam logic [31:0] PRESS_OFS = 32'd1048576;
	localparam logic [31:0] PRESS_MUL = 32'd3125;
	localparam logic signed [31:0] FINE_PRESS_OFS = 32'sd64000;
	localparam logic signed [31:0] FINE_HUM_OFS   = 32'sd76800;
	localparam logic signed [31:0] HUM_RAW_MAX    = 32'sd419430400;
	localparam logic signed [31:0] HUM_MAX        = 32'sd102400;
	localparam logic signed [26:0] TEMP_MIN       = -27'sd4000;
	localparam logic signed [26:0] TEMP_MAX       = 27'sd8500;

	typedef enum logic [2:0] {
		REG_TEMP      = 3'd0,
		REG_PRESS_LO  = 3'd1,
		REG_PRESS_HI  = 3'd2,
		REG_PRESS_NINE = 3'd3,
		REG_HUM       = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [2:0]  select_mask;
		logic [19:0] raw_pressure;
		logic [19:0] raw_temperature;
		logic [15:0] raw_humidity;
	} in_t;

	typedef struct packed {
		logic signed [14:0] temperature_centi;
		logic [16:0]        pressure_pa;
		logic [16:0]        humidity_q10;
	} out_t;

	typedef struct packed {
		logic [15:0]        t1;
		logic signed [15:0] t2;
		logic signed [15:0] t3;
		logic [15:0]        p1;
		logic signed [15:0] p2;
		logic signed [15:0] p3;
		logic signed [15:0] p4;
		logic signed [15:0] p5;
		logic signed [15:0] p6;
		logic signed [15:0] p7;
		logic signed [15:0] p8;
		logic signed [15:0] p9;
		logic [7:0]         h1;
		logic signed [15:0] h2;
		logic [7:0]         h3;
		logic signed [11:0] h4;
		logic signed [11:0] h5;
		logic signed [7:0]  h6;
	} cal_t;

	typedef struct packed {
		logic [2:0]  mask;
		logic [19:0] raw_p;
		logic [15:0] raw_h;
	} carry_t;

	typedef struct packed {
		carry_t             c;
		logic signed [31:0] fine;
	} fine_item_t;

	// signed division by 2^k, truncating toward zero
	function automatic logic signed [31:0] tdiv(input logic signed [31:0] x,
			input int unsigned k);
		logic signed [31:0] bias;
		bias = x[31] ? ((32'sd1 <<< k) - 32'sd1) : 32'sd0;
		return (x + bias) >>> k;
	endfunction

	// low word of a signed product
	function automatic logic signed [31:0] mul32(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [63:0] f;
		f = a * b;
		return $signed(f[31:0]);
	endfunction

	function automatic logic signed [14:0] temp_of(input logic signed [31:0] fine);
		logic signed [34:0] t;
		logic signed [26:0] q;
		t = 35'(fine) * 35'sd5 + 35'sd128;
		q = $signed(t[34:8]);
		if (q < TEMP_MIN)
			q = TEMP_MIN;
		else if (q > TEMP_MAX)
			q = TEMP_MAX;
		return 15'(q);
	endfunction

endpackage

FILE: rtl/psc_fine.sv
// ----------------------------------------------------------------------------
// psc_fine
// Four-stage pipeline computing the fine temperature value.
// ----------------------------------------------------------------------------
module psc_fine (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_vld,
	input  psc_pkg::in_t         in_item,
	input  psc_pkg::cal_t        cal,
	output logic                 out_vld,
	output psc_pkg::fine_item_t  out_item
);
	import psc_pkg::*;

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	carry_t c_s1, c_s2, c_s3;
	logic signed [18:0] a_s1;
	logic signed [17:0] b_s1;
	logic signed [34:0] at2_s2;
	logic signed [35:0] bb_s2;
	logic signed [23:0] v1_s3;
	logic signed [39:0] v2p_s3;
	fine_item_t item_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		c_s1   <= '{mask: in_item.select_mask, raw_p: in_item.raw_pressure,
			raw_h: in_item.raw_humidity};
		a_s1   <= $signed({2'b00, in_item.raw_temperature[19:3]})
			- $signed({2'b00, cal.t1, 1'b0});
		b_s1   <= $signed({2'b00, in_item.raw_temperature[19:4]})
			- $signed({2'b00, cal.t1});
		c_s2   <= c_s1;
		at2_s2 <= 35'(a_s1) * 35'(cal.t2);
		bb_s2  <= 36'(b_s1) * 36'(b_s1);
		c_s3   <= c_s2;
		v1_s3  <= $signed(at2_s2[34:11]);
		v2p_s3 <= 40'($signed(bb_s2[35:12])) * 40'(cal.t3);
		item_s4.c    <= c_s3;
		item_s4.fine <= 32'(v1_s3) + 32'($signed(v2p_s3[39:14]));
	end

	assign out_vld  = vld_s4;
	assign out_item = item_s4;

endmodule

FILE: rtl/psc_div.sv
// ----------------------------------------------------------------------------
// psc_div
// Pipelined restoring unsigned divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module psc_div #(
	parameter int W  = psc_pkg::DIV_W,
	parameter int TW = psc_pkg::DIV_TAG_W
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_vld,
	input  logic [W-1:0]  num,
	input  logic [W-1:0]  den,
	input  logic [TW-1:0] tag_in,
	output logic          out_vld,
	output logic [W-1:0]  quo,
	output logic [TW-1:0] tag_out
);
	import psc_pkg::*;

	logic [W-1:0]  vld_s;
	logic [W-1:0]  rem_s [W];
	logic [W-1:0]  num_s [W];
	logic [W-1:0]  den_s [W];
	logic [W-1:0]  quo_s [W];
	logic [TW-1:0] tag_s [W];

	for (genvar i = 0; i < W; i++) begin : g_stage
		logic [W-1:0]  prem, pnum, pden, pquo;
		logic [TW-1:0] ptag;
		logic          pvld;
		logic [W:0]    sh, diff;

		if (i == 0) begin : g_first
			assign prem = '0;
			assign pnum = num;
			assign pden = den;
			assign pquo = '0;
			assign ptag = tag_in;
			assign pvld = in_vld;
		end else begin : g_next
			assign prem = rem_s[i-1];
			assign pnum = num_s[i-1];
			assign pden = den_s[i-1];
			assign pquo = quo_s[i-1];
			assign ptag = tag_s[i-1];
			assign pvld = vld_s[i-1];
		end

		assign sh   = {prem, pnum[W-1-i]};
		assign diff = sh - {1'b0, pden};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[i] <= 1'b0;
			else
				vld_s[i] <= pvld;
		end

		always_ff @(posedge clk) begin
			rem_s[i] <= diff[W] ? sh[W-1:0] : diff[W-1:0];
			quo_s[i] <= {pquo[W-2:0], ~diff[W]};
			num_s[i] <= pnum;
			den_s[i] <= pden;
			tag_s[i] <= ptag;
		end
	end

	assign out_vld = vld_s[W-1];
	assign quo     = quo_s[W-1];
	assign tag_out = tag_s[W-1];

endmodule

FILE: rtl/psc_press.sv
// ----------------------------------------------------------------------------
// psc_press
// Pressure pipeline: coefficient stages, divider, correction and clamp.
// ----------------------------------------------------------------------------
module psc_press (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_vld,
	input  psc_pkg::fine_item_t in_item,
	input  psc_pkg::cal_t       cal,
	output logic                out_vld,
	output logic [16:0]         pressure
);
	import psc_pkg::*;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic vld_s7, vld_s8, vld_s9, vld_s10;
	logic [19:0] rawp_s1, rawp_s2, rawp_s3, rawp_s4;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;
	logic signed [31:0] v1_s1, q_s1;
	logic signed [31:0] qq_s2, v1p5_s2, p2v1_s2;
	logic signed [31:0] t6_s3, t3_s3, v4_s3, v1p5_s3;
	logic signed [31:0] v2_s4, y_s4;
	logic signed [31:0] z_s5;
	logic [31:0] pp_s5;
	logic signed [31:0] v1d_s6;
	logic [31:0] ppm_s6;
	logic [DIV_W-1:0] dnum, dquo;
	logic [DIV_TAG_W-1:0] dtag, dtag_o;
	logic dvld;
	logic [31:0] pq;
	logic [31:0] p_s7, p_s8, pr_s9, pd8;
	logic [31:0] sq_s7;
	logic signed [31:0] t8_s7, a9_s8, v2b_s8;
	logic zero_s7, zero_s8, zero_s9, en_s7, en_s8, en_s9;
	logic [16:0] res_s10;
	logic signed [31:0] v2a, x4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6} <= '0;
			{vld_s7, vld_s8, vld_s9, vld_s10} <= '0;
		end else begin
			vld_s1  <= in_vld;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= dvld;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
		end
	end

	always_comb begin
		v2a = t6_s3 + (v1p5_s3 <<< 1);
		x4  = tdiv(tdiv(t3_s3, 3) + v4_s3, 18);
	end

	always_ff @(posedge clk) begin
		v1_s1   <= tdiv(in_item.fine, 1) - FINE_PRESS_OFS;
		q_s1    <= tdiv(tdiv(in_item.fine, 1) - FINE_PRESS_OFS, 2);
		rawp_s1 <= in_item.c.raw_p;
		en_s1   <= in_item.c.mask[0];

		qq_s2   <= mul32(q_s1, q_s1);
		v1p5_s2 <= mul32(v1_s1, 32'(cal.p5));
		p2v1_s2 <= mul32(32'(cal.p2), v1_s1);
		rawp_s2 <= rawp_s1;
		en_s2   <= en_s1;

		t6_s3   <= mul32(tdiv(qq_s2, 11), 32'(cal.p6));
		t3_s3   <= mul32(32'(cal.p3), tdiv(qq_s2, 13));
		v4_s3   <= tdiv(p2v1_s2, 1);
		v1p5_s3 <= v1p5_s2;
		rawp_s3 <= rawp_s2;
		en_s3   <= en_s2;

		v2_s4   <= tdiv(v2a, 2) + (32'(cal.p4) <<< 16);
		y_s4    <= 32'sd32768 + x4;
		rawp_s4 <= rawp_s3;
		en_s4   <= en_s3;

		z_s5    <= mul32(y_s4, $signed({16'd0, cal.p1}));
		pp_s5   <= PRESS_OFS - {12'd0, rawp_s4} - $unsigned(tdiv(v2_s4, 12));
		en_s5   <= en_s4;

		v1d_s6  <= tdiv(z_s5, 15);
		ppm_s6  <= pp_s5 * PRESS_MUL;
		en_s6   <= en_s5;
	end

	assign dnum = ppm_s6[31] ? ppm_s6 : {ppm_s6[30:0], 1'b0};
	assign dtag = {v1d_s6 == 32'sd0, ppm_s6[31], en_s6};

	psc_div #(
		.W  (DIV_W),
		.TW (DIV_TAG_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s6),
		.num     (dnum),
		.den     ($unsigned(v1d_s6)),
		.tag_in  (dtag),
		.out_vld (dvld),
		.quo     (dquo),
		.tag_out (dtag_o)
	);

	assign pq  = dtag_o[1] ? {dquo[30:0], 1'b0} : dquo;
	assign pd8 = {3'd0, pq[31:3]};

	always_ff @(posedge clk) begin
		p_s7    <= pq;
		sq_s7   <= pd8 * pd8;
		t8_s7   <= mul32($signed({2'b00, pq[31:2]}), 32'(cal.p8));
		zero_s7 <= dtag_o[2];
		en_s7   <= dtag_o[0];

		a9_s8   <= mul32(32'(cal.p9), $signed({13'd0, sq_s7[31:13]}));
		v2b_s8  <= tdiv(t8_s7, 13);
		p_s8    <= p_s7;
		zero_s8 <= zero_s7;
		en_s8   <= en_s7;

		pr_s9   <= p_s8 + $unsigned(tdiv(tdiv(a9_s8, 12) + v2b_s8 + 32'(cal.p7), 4));
		zero_s9 <= zero_s8;
		en_s9   <= en_s8;

		if (!en_s9)
			res_s10 <= '0;
		else if (zero_s9 || pr_s9 < PRESS_MIN)
			res_s10 <= PRESS_MIN[16:0];
		else if (pr_s9 > PRESS_MAX)
			res_s10 <= PRESS_MAX[16:0];
		else
			res_s10 <= pr_s9[16:0];
	end

	assign out_vld  = vld_s10;
	assign pressure = res_s10;

endmodule

FILE: rtl/psc_hum.sv
// ----------------------------------------------------------------------------
// psc_hum
// Ten-stage humidity pipeline with clamp.
// ----------------------------------------------------------------------------
module psc_hum (
	input  logic                clk,
	input  psc_pkg::fine_item_t in_item,
	input  psc_pkg::cal_t       cal,
	output logic [16:0]         humidity
);
	import psc_pkg::*;

	logic signed [31:0] v1_s1;
	logic [15:0] rawh_s1;
	logic signed [31:0] mh5_s2, mh6_s2, mh3_s2, v2r_s2;
	logic signed [31:0] v5_s3, a2_s3, a3_s3;
	logic signed [31:0] m_s4, v5_s4;
	logic signed [31:0] v4_s5, v5_s5;
	logic signed [31:0] m2_s6, v5_s6;
	logic signed [31:0] v3_s7;
	logic signed [31:0] sq_s8, v3_s8;
	logic signed [31:0] mh1_s9, v3_s9;
	logic [16:0] res_s10;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7, en_s8, en_s9;
	logic signed [31:0] d8, vf;

	assign d8 = tdiv(v3_s7, 15);

	always_comb begin
		vf = v3_s9 - tdiv(mh1_s9, 4);
		if (vf < 32'sd0)
			vf = 32'sd0;
		if (vf > HUM_RAW_MAX)
			vf = HUM_RAW_MAX;
		vf = vf >>> 12;
		if (vf > HUM_MAX)
			vf = HUM_MAX;
	end

	always_ff @(posedge clk) begin
		v1_s1   <= in_item.fine - FINE_HUM_OFS;
		rawh_s1 <= in_item.c.raw_h;
		en_s1   <= in_item.c.mask[2];

		mh5_s2  <= mul32(32'(cal.h5), v1_s1);
		mh6_s2  <= mul32(v1_s1, 32'(cal.h6));
		mh3_s2  <= mul32(v1_s1, $signed({24'd0, cal.h3}));
		v2r_s2  <= $signed({2'b00, rawh_s1, 14'd0});
		en_s2   <= en_s1;

		v5_s3   <= tdiv(v2r_s2 - (32'(cal.h4) <<< 20) - mh5_s2 + 32'sd16384, 15);
		a2_s3   <= tdiv(mh6_s2, 10);
		a3_s3   <= tdiv(mh3_s2, 11) + 32'sd32768;
		en_s3   <= en_s2;

		m_s4    <= mul32(a2_s3, a3_s3);
		v5_s4   <= v5_s3;
		en_s4   <= en_s3;

		v4_s5   <= tdiv(m_s4, 10) + 32'sd2097152;
		v5_s5   <= v5_s4;
		en_s5   <= en_s4;

		m2_s6   <= mul32(v4_s5, 32'(cal.h2));
		v5_s6   <= v5_s5;
		en_s6   <= en_s5;

		v3_s7   <= mul32(v5_s6, tdiv(m2_s6 + 32'sd8192, 14));
		en_s7   <= en_s6;

		sq_s8   <= mul32(d8, d8);
		v3_s8   <= v3_s7;
		en_s8   <= en_s7;

		mh1_s9  <= mul32(tdiv(sq_s8, 7), $signed({24'd0, cal.h1}));
		v3_s9   <= v3_s8;
		en_s9   <= en_s8;

		res_s10 <= en_s9 ? vf[16:0] : '0;
	end

	assign humidity = res_s10;

endmodule

FILE: rtl/pth_sensor_compensation.sv
// ----------------------------------------------------------------------------
// pth_sensor_compensation
// Calibrated temperature, pressure and humidity from raw sensor readings.
// ----------------------------------------------------------------------------
// A request is taken in every clock cycle (busy stays low) and its result
// appears on result with done high; results leave in request order and
// cannot be held off. The latency is set by the pressure path: a 4-stage
// fine-temperature pipeline, 6 coefficient stages, a 32-stage one-bit-per-stage
// divider and 4 correction stages. Calibration registers sit on the APB port at
// byte addresses 8*i; the user must write them only while idle (not enforced).
module pth_sensor_compensation (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  psc_pkg::in_t     req,
	output logic             done,
	output psc_pkg::out_t    result,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [5:0]       paddr,
	input  logic [63:0]      pwdata,
	output logic [63:0]      prdata,
	output logic             pready
);
	import psc_pkg::*;

	localparam int HUM_DLY = PRESS_LAT - HUM_LAT;

	logic [47:0] temp_calib_q;
	logic [63:0] press_lo_q, press_hi_q, hum_calib_q;
	logic [15:0] press_nine_q;
	cal_t cal;
	logic fvld, pvld;
	fine_item_t fitem;
	logic [16:0] press, hum;
	logic signed [14:0] temp_s [PRESS_LAT];
	logic [16:0] hum_s [HUM_DLY];

	assign pready = 1'b1;
	assign busy   = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_calib_q <= '0;
			press_lo_q   <= '0;
			press_hi_q   <= '0;
			press_nine_q <= '0;
			hum_calib_q  <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx_t'(paddr[5:3]))
				REG_TEMP:       temp_calib_q <= pwdata[47:0];
				REG_PRESS_LO:   press_lo_q   <= pwdata;
				REG_PRESS_HI:   press_hi_q   <= pwdata;
				REG_PRESS_NINE: press_nine_q <= pwdata[15:0];
				REG_HUM:        hum_calib_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[5:3]))
			REG_TEMP:       prdata = {16'd0, temp_calib_q};
			REG_PRESS_LO:   prdata = press_lo_q;
			REG_PRESS_HI:   prdata = press_hi_q;
			REG_PRESS_NINE: prdata = {48'd0, press_nine_q};
			REG_HUM:        prdata = hum_calib_q;
			default:        prdata = '0;
		endcase
	end

	always_comb begin
		cal.t1 = temp_calib_q[15:0];
		cal.t2 = $signed(temp_calib_q[31:16]);
		cal.t3 = $signed(temp_calib_q[47:32]);
		cal.p1 = press_lo_q[15:0];
		cal.p2 = $signed(press_lo_q[31:16]);
		cal.p3 = $signed(press_lo_q[47:32]);
		cal.p4 = $signed(press_lo_q[63:48]);
		cal.p5 = $signed(press_hi_q[15:0]);
		cal.p6 = $signed(press_hi_q[31:16]);
		cal.p7 = $signed(press_hi_q[47:32]);
		cal.p8 = $signed(press_hi_q[63:48]);
		cal.p9 = $signed(press_nine_q);
		cal.h1 = hum_calib_q[7:0];
		cal.h2 = $signed(hum_calib_q[23:8]);
		cal.h3 = hum_calib_q[31:24];
		cal.h4 = $signed(hum_calib_q[43:32]);
		cal.h5 = $signed(hum_calib_q[55:44]);
		cal.h6 = $signed(hum_calib_q[63:56]);
	end

	psc_fine u_fine (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (start && !busy),
		.in_item  (req),
		.cal      (cal),
		.out_vld  (fvld),
		.out_item (fitem)
	);

	psc_press u_press (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (fvld),
		.in_item  (fitem),
		.cal      (cal),
		.out_vld  (pvld),
		.pressure (press)
	);

	psc_hum u_hum (
		.clk      (clk),
		.in_item  (fitem),
		.cal      (cal),
		.humidity (hum)
	);

	always_ff @(posedge clk) begin
		temp_s[0] <= (fitem.c.mask != 3'd0) ? temp_of(fitem.fine) : 15'sd0;
		for (int i = 1; i < PRESS_LAT; i++)
			temp_s[i] <= temp_s[i-1];
		hum_s[0] <= hum;
		for (int i = 1; i < HUM_DLY; i++)
			hum_s[i] <= hum_s[i-1];
	end

	assign done                     = pvld;
	assign result.temperature_centi = temp_s[PRESS_LAT-1];
	assign result.pressure_pa       = press;
	assign result.humidity_q10      = hum_s[HUM_DLY-1];

`ifndef SYNTH
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, TOTAL_LAT))
		else $error("result without matching request");
	a_press_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.pressure_pa == 17'd0
			|| (result.pressure_pa >= PRESS_MIN[16:0]
			&& result.pressure_pa <= PRESS_MAX[16:0])))
		else $error("pressure out of range");
	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.humidity_q10 <= HUM_MAX[16:0]))
		else $error("humidity out of range");
	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.temperature_centi >= 15'(TEMP_MIN)
			&& result.temperature_centi <= 15'(TEMP_MAX)))
		else $error("temperature out of range");
`endif

endmodule

FILE: dv/tb_pth_sensor_compensation.sv
// ----------------------------------------------------------------------------
// tb_pth_sensor_compensation
// Self-checking bench for the sensor compensation block: a queue-fed driver
// issues requests under varying idle patterns, a bit-exact predictor computes
// each expected result at acceptance, and a monitor checks the results in
// order. Calibration is reloaded over APB between drained phases.
// ----------------------------------------------------------------------------
module tb_pth_sensor_compensation;
	import psc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	in_t         req;
	logic        done;
	out_t        result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [5:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	logic [63:0] cal_temp, cal_plo, cal_phi, cal_p9, cal_hum;
	in_t         pending_q[$];
	out_t        comp_q[$];
	int          idle_pct;
	int          errors;
	int          cycles;

	pth_sensor_compensation u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .result(result), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int fine_of(logic [19:0] raw_t);
		longint t1, t2, t3, a, b, v1, v2;
		t1 = longint'(cal_temp[15:0]);
		t2 = longint'($signed(cal_temp[31:16]));
		t3 = longint'($signed(cal_temp[47:32]));
		a = longint'(raw_t >> 3) - 2 * t1;
		b = longint'(raw_t >> 4) - t1;
		v1 = (a * t2) >>> 11;
		v2 = (((b * b) >>> 12) * t3) >>> 14;
		return int'(v1 + v2);
	endfunction

	function automatic int unsigned press_of(int fine, logic [19:0] raw_p);
		int p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, v3, v4, q, t;
		int unsigned p, sq;
		p1 = int'(cal_plo[15:0]);
		p2 = int'($signed(cal_plo[31:16]));
		p3 = int'($signed(cal_plo[47:32]));
		p4 = int'($signed(cal_plo[63:48]));
		p5 = int'($signed(cal_phi[15:0]));
		p6 = int'($signed(cal_phi[31:16]));
		p7 = int'($signed(cal_phi[47:32]));
		p8 = int'($signed(cal_phi[63:48]));
		p9 = int'($signed(cal_p9[15:0]));
		v1 = fine / 2 - 64000;
		q = v1 / 4;
		v2 = ((q * q) / 2048) * p6;
		v2 = v2 + (v1 * p5) * 2;
		v2 = v2 / 4 + p4 * 65536;
		v3 = (p3 * ((q * q) / 8192)) / 8;
		v4 = (p2 * v1) / 2;
		v1 = (v3 + v4) / 262144;
		v1 = ((32768 + v1) * p1) / 32768;
		if (v1 == 0)
			return 30000;
		t = v2 / 4096;
		p = 32'd1048576 - 32'(raw_p);
		p = (p - unsigned'(t)) * 32'd3125;
		if (p < 32'h8000_0000)
			p = (p << 1) / unsigned'(v1);
		else
			p = (p / unsigned'(v1)) * 32'd2;
		sq = (p / 8) * (p / 8);
		v1 = (p9 * int'(sq / 8192)) / 4096;
		v2 = (int'(p / 4) * p8) / 8192;
		t = int'(p) + (v1 + v2 + p7) / 16;
		p = unsigned'(t);
		if (p < 30000)
			p = 30000;
		else if (p > 110000)
			p = 110000;
		return p;
	endfunction

	function automatic int unsigned hum_of(int fine, logic [15:0] raw_h);
		int h1, h2, h3, h4, h5, h6, v1, v2, v3, v4, v5;
		h1 = int'(cal_hum[7:0]);
		h2 = int'($signed(cal_hum[23:8]));
		h3 = int'(cal_hum[31:24]);
		h4 = int'($signed(cal_hum[43:32]));
		h5 = int'($signed(cal_hum[55:44]));
		h6 = int'($signed(cal_hum[63:56]));
		v1 = fine - 76800;
		v2 = int'(32'(raw_h) * 32'd16384);
		v3 = h4 * 1048576;
		v4 = h5 * v1;
		v5 = (v2 - v3 - v4 + 16384) / 32768;
		v2 = (v1 * h6) / 1024;
		v3 = (v1 * h3) / 2048;
		v4 = (v2 * (v3 + 32768)) / 1024 + 2097152;
		v2 = (v4 * h2 + 8192) / 16384;
		v3 = v5 * v2;
		v4 = ((v3 / 32768) * (v3 / 32768)) / 128;
		v5 = v3 - (v4 * h1) / 16;
		if (v5 < 0)
			v5 = 0;
		if (v5 > 419430400)
			v5 = 419430400;
		v5 = v5 / 4096;
		if (v5 > 102400)
			v5 = 102400;
		return unsigned'(v5);
	endfunction

	function automatic out_t compensate(in_t r);
		out_t   o;
		int     fine;
		longint t;
		o = '0;
		if (r.select_mask != 3'b000) begin
			fine = fine_of(r.raw_temperature);
			t = (longint'(fine) * 5 + 128) >>> 8;
			if (t < -4000)
				t = -4000;
			else if (t > 8500)
				t = 8500;
			o.temperature_centi = 15'(t);
			if (r.select_mask[0])
				o.pressure_pa = 17'(press_of(fine, r.raw_pressure));
			if (r.select_mask[2])
				o.humidity_q10 = 17'(hum_of(fine, r.raw_humidity));
		end
		return o;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req   <= '0;
		end else begin
			if (start && !busy)
				comp_q.push_back(compensate(req));
			if (!start || !busy) begin
				if (pending_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
					req   <= pending_q.pop_front();
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	// monitor
	always @(posedge clk) begin
		out_t want;
		if (arst_n && done) begin
			if (comp_q.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				want = comp_q.pop_front();
				if (result.temperature_centi !== want.temperature_centi)
					report_mismatch("temperature_centi", result.temperature_centi,
						want.temperature_centi);
				if (result.pressure_pa !== want.pressure_pa)
					report_mismatch("pressure_pa", result.pressure_pa, want.pressure_pa);
				if (result.humidity_q10 !== want.humidity_q10)
					report_mismatch("humidity_q10", result.humidity_q10, want.humidity_q10);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic apb_write(logic [2:0] idx, logic [63:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_TEMP:       cal_temp = value & 64'h0000_FFFF_FFFF_FFFF;
			REG_PRESS_LO:   cal_plo  = value;
			REG_PRESS_HI:   cal_phi  = value;
			REG_PRESS_NINE: cal_p9   = value & 64'hFFFF;
			REG_HUM:        cal_hum  = value;
			default:        ;
		endcase
	endtask

	task automatic load_cal(logic [63:0] t, logic [63:0] lo, logic [63:0] hi,
			logic [63:0] nine, logic [63:0] h);
		apb_write(REG_TEMP, t);
		apb_write(REG_PRESS_LO, lo);
		apb_write(REG_PRESS_HI, hi);
		apb_write(REG_PRESS_NINE, nine);
		apb_write(REG_HUM, h);
	endtask

	function automatic in_t rand_request(bit typical);
		in_t r;
		r.select_mask  = 3'($urandom_range(7));
		r.raw_humidity = 16'($urandom);
		if (typical) begin
			r.raw_temperature = 20'(415148 + $urandom_range(120000) - 60000);
			r.raw_pressure    = 20'(519888 + $urandom_range(300000) - 150000);
			if ($urandom_range(1))
				r.raw_humidity = 16'(20000 + $urandom_range(30000));
		end else begin
			r.raw_temperature = 20'($urandom);
			r.raw_pressure    = 20'($urandom);
		end
		return r;
	endfunction

	task automatic drain();
		wait (pending_q.size() == 0 && comp_q.size() == 0 && !start);
		repeat (50) @(posedge clk);
	endtask

	localparam logic [63:0] TYP_T  = {16'd0, 16'hFC18, 16'd26435, 16'd27504};
	localparam logic [63:0] TYP_LO = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
	localparam logic [63:0] TYP_HI = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
	localparam logic [63:0] TYP_P9 = 64'd6000;
	localparam logic [63:0] TYP_H  = {8'd30, 12'd0, 12'd324, 8'd0, 16'd362, 8'd75};

	initial begin
		int phase_idle[6] = '{0, 49, 27, 0, 49, 27};
		in_t r;
		errors   = 0;
		cycles   = 0;
		idle_pct = 0;
		cal_temp = '0;
		cal_plo  = '0;
		cal_phi  = '0;
		cal_p9   = '0;
		cal_hum  = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		arst_n   = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset calibration: zero divisor path, pressure floors
		for (int m = 0; m < 8; m++) begin
			r = rand_request(1'b0);
			r.select_mask = 3'(m);
			pending_q.push_back(r);
		end
		drain();

		load_cal(TYP_T, TYP_LO, TYP_HI, TYP_P9, TYP_H);
		// out-of-range register index is ignored
		apb_write(3'd5, 64'hFFFF_FFFF_FFFF_FFFF);
		for (int m = 0; m < 8; m++) begin
			r = rand_request(1'b1);
			r.select_mask = 3'(m);
			pending_q.push_back(r);
		end
		r = '0;
		r.select_mask = 3'b111;
		pending_q.push_back(r);
		r = '1;
		pending_q.push_back(r);
		r.raw_pressure = '0;
		r.raw_humidity = '0;
		pending_q.push_back(r);
		r.raw_temperature = '0;
		r.raw_pressure    = '1;
		r.raw_humidity    = '1;
		pending_q.push_back(r);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			idle_pct = phase_idle[ph];
			case (ph)
				0: load_cal(TYP_T, TYP_LO, TYP_HI, TYP_P9, TYP_H);
				1: load_cal('1, '1, '1, '1, '1);
				2: load_cal({16'h0, 16'h8000, 16'h8000, 16'hFFFF},
					{4{16'h8000}} | 64'hFFFF, {4{16'h8000}}, 64'h8000,
					{8'h80, 12'h800, 12'h800, 8'hFF, 16'h8000, 8'hFF});
				3: load_cal({$urandom, $urandom}, {$urandom, $urandom},
					{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
				4: load_cal({16'h0, 16'h7FFF, 16'h7FFF, 16'h0},
					{4{16'h7FFF}}, {4{16'h7FFF}}, 64'h7FFF,
					{8'h7F, 12'h7FF, 12'h7FF, 8'h00, 16'h7FFF, 8'h00});
				default: load_cal(TYP_T ^ 64'($urandom_range(255)),
					TYP_LO ^ 64'($urandom_range(255)), TYP_HI, TYP_P9, TYP_H);
			endcase
			for (int i = 0; i < 315; i++)
				pending_q.push_back(rand_request(ph == 0 || ph == 5 ?
					$urandom_range(99) < 80 : $urandom_range(1)));
			drain();
		end

		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/psc_pkg.sv
rtl/psc_fine.sv
rtl/psc_div.sv
rtl/psc_press.sv
rtl/psc_hum.sv
rtl/pth_sensor_compensation.sv
dv/tb_pth_sensor_compensation.sv
